// ----- src/conv3x3_gray_clamp_core_assert.svh -----
// Assertion macros for the 3x3 convolution core.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef CONV3X3_GRAY_CLAMP_CORE_ASSERT_SVH
`define CONV3X3_GRAY_CLAMP_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define C3GC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define C3GC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define C3GC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define C3GC_ASSERT(label, prop, msg)
`define C3GC_NEVER(label, cond, msg)
`define C3GC_ASSERT_RST(label, prop, msg)
`endif
`endif

// ----- src/c3gc_pkg.sv -----
// Shared types and constants of the 3x3 convolution core.
// No dependencies; used by every module of the block except c3gc_ram.
package c3gc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int PIXEL_BITS = 8;
  localparam int COEFF_BITS = 8;
  localparam int X_BITS     = $clog2(MAX_WIDTH);
  localparam int W_BITS     = X_BITS + 1;
  localparam int ROW_BITS   = 17;
  localparam int PROD_BITS  = PIXEL_BITS + COEFF_BITS + 1;
  localparam int SUM_BITS   = 20;
  localparam int MAG_BITS   = SUM_BITS - 1;
  localparam int DIV_BITS   = 16;
  localparam int CNT_BITS   = $clog2(MAG_BITS + 1);
  localparam int CLAMP_MAX  = 255;

  localparam logic [2:0] CFG_KERN_XM = 3'd0;
  localparam logic [2:0] CFG_KERN_XC = 3'd1;
  localparam logic [2:0] CFG_KERN_XP = 3'd2;
  localparam logic [2:0] CFG_DIVISOR = 3'd3;
  localparam logic [2:0] CFG_FWIDTH  = 3'd4;
  localparam logic [2:0] CFG_FHEIGHT = 3'd5;

  typedef struct packed {
    logic [7:0] pixel;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] value;
    logic               frame_end;
  } out_item_t;

  typedef struct packed {
    logic [2:0][3*COEFF_BITS-1:0] kern;
    logic [15:0]                  divisor;
    logic [10:0]                  frame_width;
    logic [15:0]                  frame_height;
  } cfg_t;

  // One classified slot handed from the front to the back.
  typedef struct packed {
    logic [PIXEL_BITS-1:0] pix;
    logic [X_BITS-1:0]     x;
    logic                  emit;
    logic                  top_ok;
    logic                  bot_ok;
    logic                  left_ok;
    logic                  right_ok;
    logic                  last;
  } q_ent_t;

endpackage

// ----- src/conv3x3_gray_clamp_core.sv -----
// Top level of the streaming 3x3 gray convolution: configuration registers and wiring.
// Depends on c3gc_pkg, c3gc_front, c3gc_queue, c3gc_back and the assertion header.
//
//  channel  direction  payload                  handshake
//  in_      input      pixel, flush             in_valid / in_ready
//  out_     output     value, frame_end         out_valid / out_ready
//  cfg_     input      cfg_index, cfg_data      cfg_valid / cfg_ready
//
// A slot without a result passes the back end as a line store read, then a write
// and window shift; a slot with a result then also passes the multiply, sum, divide and
// output states, with a bit-serial divider that produces one quotient bit per cycle over 19 bits.
// Flushes inside the pixel area are taken and dropped by the front end.
// Reset is synchronous; the line stores need no clearing pass. Either side may stall freely:
// a two-entry queue and an output register decouple the input and the result transfers.
`include "conv3x3_gray_clamp_core_assert.svh"
module conv3x3_gray_clamp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  c3gc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output c3gc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);

  c3gc_pkg::cfg_t   cfg_r, cfg_nxt;
  c3gc_pkg::q_ent_t push_ent, head;
  logic             q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        c3gc_pkg::CFG_KERN_XM: cfg_nxt.kern[0]      = cfg_data;
        c3gc_pkg::CFG_KERN_XC: cfg_nxt.kern[1]      = cfg_data;
        c3gc_pkg::CFG_KERN_XP: cfg_nxt.kern[2]      = cfg_data;
        c3gc_pkg::CFG_DIVISOR: cfg_nxt.divisor      = cfg_data[15:0];
        c3gc_pkg::CFG_FWIDTH:  cfg_nxt.frame_width  = cfg_data[10:0];
        c3gc_pkg::CFG_FHEIGHT: cfg_nxt.frame_height = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kern[0]      <= 24'd0;
      cfg_r.kern[1]      <= 24'd256;
      cfg_r.kern[2]      <= 24'd0;
      cfg_r.divisor      <= 16'd1;
      cfg_r.frame_width  <= 11'd1024;
      cfg_r.frame_height <= 16'd1024;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  c3gc_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_full(q_full), .q_push(q_push), .q_ent(push_ent)
  );

  c3gc_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_ent(push_ent), .pop(q_pop),
    .head(head), .full(q_full), .empty(q_empty)
  );

  c3gc_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_empty(q_empty), .q_head(head), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  `C3GC_NEVER(a_no_overflow, q_push && q_full && !q_pop, "queue overflow")
  `C3GC_NEVER(a_no_underflow, q_pop && q_empty, "queue underflow")
  `C3GC_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && !q_pop, "activity after reset")

endmodule

// ----- src/c3gc_ram.sv -----
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module c3gc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/c3gc_front.sv -----
// Front end: accepts input transfers, tracks the frame position and classifies slots.
// Depends on c3gc_pkg.
module c3gc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  c3gc_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  c3gc_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output c3gc_pkg::q_ent_t  q_ent
);

  logic [c3gc_pkg::X_BITS-1:0]   col_r, col_nxt;
  logic [c3gc_pkg::ROW_BITS-1:0] row_r, row_nxt;
  logic [c3gc_pkg::W_BITS-1:0]   cur_w_r, cur_w_nxt;
  logic [15:0]                   cur_h_r, cur_h_nxt;

  logic                          start, accept, in_pixels, drop, xnz;
  logic [c3gc_pkg::W_BITS-1:0]   w, clamp_w, x_inc;
  logic [15:0]                   h, clamp_h;
  logic [c3gc_pkg::X_BITS-1:0]   ox, w_m1;
  logic [c3gc_pkg::ROW_BITS-1:0] oy, h_ext;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign start    = (col_r == '0) && (row_r == '0);

  always_comb begin
    if (cfg.frame_width == 11'd0) begin
      clamp_w = c3gc_pkg::W_BITS'(1);
    end else if (32'(cfg.frame_width) > c3gc_pkg::MAX_WIDTH) begin
      clamp_w = c3gc_pkg::W_BITS'(c3gc_pkg::MAX_WIDTH);
    end else begin
      clamp_w = c3gc_pkg::W_BITS'(cfg.frame_width);
    end
    clamp_h = (cfg.frame_height == 16'd0) ? 16'd1 : cfg.frame_height;
  end

  assign w         = start ? clamp_w : cur_w_r;
  assign h         = start ? clamp_h : cur_h_r;
  assign h_ext     = c3gc_pkg::ROW_BITS'(h);
  assign in_pixels = row_r < h_ext;
  assign drop      = in_pixels && in_data.flush;
  assign xnz       = col_r != '0;
  assign w_m1      = c3gc_pkg::X_BITS'(w - c3gc_pkg::W_BITS'(1));
  assign ox        = xnz ? col_r - c3gc_pkg::X_BITS'(1) : w_m1;
  assign oy        = xnz ? row_r - c3gc_pkg::ROW_BITS'(1) : row_r - c3gc_pkg::ROW_BITS'(2);
  assign x_inc     = c3gc_pkg::W_BITS'(col_r) + c3gc_pkg::W_BITS'(1);

  always_comb begin
    q_ent.pix      = in_pixels ? in_data.pixel : '0;
    q_ent.x        = col_r;
    q_ent.emit     = (row_r >= c3gc_pkg::ROW_BITS'(1)) &&
                     (xnz || (row_r >= c3gc_pkg::ROW_BITS'(2)));
    q_ent.top_ok   = oy != '0;
    q_ent.bot_ok   = (oy + c3gc_pkg::ROW_BITS'(1)) < h_ext;
    q_ent.left_ok  = ox != '0;
    q_ent.right_ok = (c3gc_pkg::W_BITS'(ox) + c3gc_pkg::W_BITS'(1)) < w;
    q_ent.last     = q_ent.emit && (ox == w_m1) && (oy == h_ext - c3gc_pkg::ROW_BITS'(1));
  end

  assign q_push = accept && !drop;

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    cur_w_nxt = cur_w_r;
    cur_h_nxt = cur_h_r;
    if (accept && start) begin
      cur_w_nxt = clamp_w;
      cur_h_nxt = clamp_h;
    end
    if (q_push) begin
      if (x_inc >= w) begin
        col_nxt = '0;
        row_nxt = row_r + c3gc_pkg::ROW_BITS'(1);
      end else begin
        col_nxt = c3gc_pkg::X_BITS'(x_inc);
      end
      if (q_ent.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      cur_w_r <= c3gc_pkg::W_BITS'(c3gc_pkg::MAX_WIDTH);
      cur_h_r <= 16'd1024;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      cur_w_r <= cur_w_nxt;
      cur_h_r <= cur_h_nxt;
    end
  end

endmodule

// ----- src/c3gc_queue.sv -----
// Two-entry queue between the front end and the back end.
// Depends on c3gc_pkg.
module c3gc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  c3gc_pkg::q_ent_t push_ent,
  input  logic             pop,
  output c3gc_pkg::q_ent_t head,
  output logic             full,
  output logic             empty
);

  c3gc_pkg::q_ent_t ent_r [2];
  logic       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head  = ent_r[rd_r];
  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;

  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/c3gc_back.sv -----
// Back end: line stores, 3x3 window, weighted sum, bit-serial divider and clamp.
// Depends on c3gc_pkg and c3gc_ram.
module c3gc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  c3gc_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  c3gc_pkg::q_ent_t   q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output c3gc_pkg::out_item_t out_data
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_WIN  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_SUM  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  c3gc_pkg::q_ent_t ent_r;

  logic [c3gc_pkg::PIXEL_BITS-1:0] win_r [3][3];
  logic signed [c3gc_pkg::PROD_BITS-1:0] prod_r [3][3];
  logic [c3gc_pkg::PIXEL_BITS-1:0] upper_rd, lower_rd;

  logic                            neg_r;
  logic [c3gc_pkg::MAG_BITS-1:0]   quo_r;
  logic [c3gc_pkg::DIV_BITS-1:0]   rem_r;
  logic [c3gc_pkg::CNT_BITS-1:0]   cnt_r;
  logic                            out_valid_r;
  c3gc_pkg::out_item_t             out_r;

  logic signed [c3gc_pkg::SUM_BITS-1:0] sum;
  logic [c3gc_pkg::SUM_BITS-1:0]        mag;
  logic [c3gc_pkg::DIV_BITS-1:0]        dvs;
  logic [c3gc_pkg::DIV_BITS:0]          trial;
  logic                                 qbit;
  logic signed [c3gc_pkg::SUM_BITS-1:0] result;
  logic                                 out_free, ram_we;

  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign ram_we   = state_r == ST_WIN;
  assign out_free = !out_valid_r || out_ready;

  c3gc_ram #(.WIDTH(c3gc_pkg::PIXEL_BITS), .DEPTH(c3gc_pkg::MAX_WIDTH)) u_upper (
    .clk(clk), .we(ram_we), .waddr(ent_r.x), .wdata(lower_rd),
    .raddr(q_head.x), .rdata(upper_rd)
  );

  c3gc_ram #(.WIDTH(c3gc_pkg::PIXEL_BITS), .DEPTH(c3gc_pkg::MAX_WIDTH)) u_lower (
    .clk(clk), .we(ram_we), .waddr(ent_r.x), .wdata(ent_r.pix),
    .raddr(q_head.x), .rdata(lower_rd)
  );

  always_comb begin
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sum = sum + c3gc_pkg::SUM_BITS'(prod_r[r][c]);
      end
    end
    mag   = sum[c3gc_pkg::SUM_BITS-1] ? -sum : sum;
    dvs   = (cfg.divisor == '0) ? c3gc_pkg::DIV_BITS'(1) : cfg.divisor;
    trial = {rem_r, quo_r[c3gc_pkg::MAG_BITS-1]};
    qbit  = trial >= {1'b0, dvs};
  end

  always_comb begin
    if (neg_r) begin
      result = -$signed({1'b0, quo_r});
    end else if (quo_r > c3gc_pkg::MAG_BITS'(c3gc_pkg::CLAMP_MAX)) begin
      result = c3gc_pkg::SUM_BITS'(c3gc_pkg::CLAMP_MAX);
    end else begin
      result = $signed({1'b0, quo_r});
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!q_empty) state_nxt = ST_WIN;
      ST_WIN:  state_nxt = ent_r.emit ? ST_MUL : ST_IDLE;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == c3gc_pkg::CNT_BITS'(c3gc_pkg::MAG_BITS - 1)) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers; the window is the only part that needs a reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (state_r == ST_WIN) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= upper_rd;
      win_r[1][2] <= lower_rd;
      win_r[2][2] <= ent_r.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_head;
    end
    if (state_r == ST_MUL) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if ((r == 0 && !ent_r.top_ok) || (r == 2 && !ent_r.bot_ok) ||
              (c == 0 && !ent_r.left_ok) || (c == 2 && !ent_r.right_ok)) begin
            prod_r[r][c] <= '0;
          end else begin
            prod_r[r][c] <= c3gc_pkg::PROD_BITS'(
              $signed({1'b0, win_r[r][c]}) *
              $signed(cfg.kern[c][r*c3gc_pkg::COEFF_BITS +: c3gc_pkg::COEFF_BITS]));
          end
        end
      end
    end
    if (state_r == ST_SUM) begin
      neg_r <= sum[c3gc_pkg::SUM_BITS-1];
      quo_r <= mag[c3gc_pkg::MAG_BITS-1:0];
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (state_r == ST_DIV) begin
      // One quotient bit per cycle, dividend bits shift out as quotient bits shift in.
      rem_r <= qbit ? c3gc_pkg::DIV_BITS'(trial - {1'b0, dvs}) : trial[c3gc_pkg::DIV_BITS-1:0];
      quo_r <= {quo_r[c3gc_pkg::MAG_BITS-2:0], qbit};
      cnt_r <= cnt_r + c3gc_pkg::CNT_BITS'(1);
    end
    if (state_r == ST_OUT && out_free) begin
      out_r.value     <= result;
      out_r.frame_end <= ent_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
